// ===== hdl/btd_pkg.sv =====
// Shared types and codes of the bounded task dispatcher.
package btd_pkg;

  // Classified command, encoded as the incoming kind field
  typedef enum logic [3:0] {
    CMD_ADD         = 4'd0,
    CMD_CANCEL      = 4'd1,
    CMD_KILL        = 4'd2,
    CMD_COMPLETE    = 4'd3,
    CMD_STOP        = 4'd4,
    CMD_RESUME      = 4'd5,
    CMD_CANCEL_PEND = 4'd6,
    CMD_CANCEL_RUN  = 4'd7,
    CMD_CANCEL_ALL  = 4'd8,
    CMD_KILL_ALL    = 4'd9,
    CMD_TICK        = 4'd10,
    CMD_NOP         = 4'd11
  } cmd_t;

  // Event codes on the result channel
  typedef enum logic [2:0] {
    EV_RUN    = 3'd0,
    EV_CANCEL = 3'd1,
    EV_KILL   = 3'd2,
    EV_DONE   = 3'd3,
    EV_EMPTY  = 3'd4
  } ev_t;

  // Bit positions of the per-slot flags
  localparam int F_CANCELLED  = 0;
  localparam int F_KILLED     = 1;
  localparam int F_RUN_EXP    = 2;
  localparam int F_CANCEL_EXP = 3;

  localparam int KIND_W  = 4;
  localparam int SLOT_W  = 4;
  localparam int LIMIT_W = 20;
  localparam int MAXRUN_W = 5;

endpackage

// ===== hdl/btd_if.sv =====
// Command and event channel interfaces of the bounded task dispatcher.
interface btd_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  kind;
  logic [3:0]  slot;
  logic [19:0] run_limit_ms;
  logic [19:0] cancel_limit_ms;

  modport source (output valid, kind, slot, run_limit_ms, cancel_limit_ms, input ready);
  modport sink (input valid, kind, slot, run_limit_ms, cancel_limit_ms, output ready);
endinterface

interface btd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [3:0] task_res;
  logic       was_cancelled;
  logic       was_killed;
  logic       run_expired;
  logic       cancel_expired;
  logic       last;

  modport source (output valid, event_res, task_res, was_cancelled, was_killed,
                  run_expired, cancel_expired, last, input ready);
  modport sink (input valid, event_res, task_res, was_cancelled, was_killed,
                run_expired, cancel_expired, last, output ready);
endinterface

// ===== hdl/btd_front.sv =====
// Front end: accepts commands, checks the slot and saturates the limits.
module btd_front import btd_pkg::*; #(
  parameter int NUM_SLOTS  = 16,
  parameter int TIMER_BITS = 20
) (
  btd_in_if.sink                       cmd,
  output logic                         push_valid,
  input  logic                         push_ready,
  output cmd_t                         push_cmd,
  output logic [$clog2(NUM_SLOTS)-1:0] push_slot,
  output logic [TIMER_BITS-1:0]        push_run,
  output logic [TIMER_BITS-1:0]        push_can
);
  localparam int SW = $clog2(NUM_SLOTS);
  localparam logic [31:0] TMAX = 32'hFFFF_FFFF >> (32 - TIMER_BITS);

  logic [SW+3:0] slot_ext;
  logic          slot_ok;
  logic [31:0]   run32;
  logic [31:0]   can32;

  assign push_valid = cmd.valid;
  assign cmd.ready  = push_ready;

  // Check the addressed slot against the slot count
  assign slot_ext  = {{SW{1'b0}}, cmd.slot};
  assign slot_ok   = slot_ext < (SW + 4)'(NUM_SLOTS);
  assign push_slot = slot_ext[SW-1:0];

  // Saturate limits to the timer width
  assign run32    = 32'(cmd.run_limit_ms);
  assign can32    = 32'(cmd.cancel_limit_ms);
  assign push_run = (run32 > TMAX) ? TMAX[TIMER_BITS-1:0] : run32[TIMER_BITS-1:0];
  assign push_can = (can32 > TMAX) ? TMAX[TIMER_BITS-1:0] : can32[TIMER_BITS-1:0];

  // Classify the kind; slot commands on a bad slot only dispatch
  always_comb begin
    case (cmd.kind)
      CMD_ADD, CMD_CANCEL, CMD_KILL, CMD_COMPLETE: begin
        push_cmd = slot_ok ? cmd_t'(cmd.kind) : CMD_NOP;
      end
      CMD_STOP, CMD_RESUME, CMD_CANCEL_PEND, CMD_CANCEL_RUN,
      CMD_CANCEL_ALL, CMD_KILL_ALL, CMD_TICK: begin
        push_cmd = cmd_t'(cmd.kind);
      end
      default: begin
        push_cmd = CMD_NOP;
      end
    endcase
  end
endmodule

// ===== hdl/btd_cmd_queue.sv =====
// Two-entry command queue between the front end and the sequencer.
module btd_cmd_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  logic [WIDTH-1:0] entry [2];
  logic             wp;
  logic             rp;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entry[rp];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store incoming transactions
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wp] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wp <= ~wp;
      end
      if (do_pop) begin
        rp <= ~rp;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end
endmodule

// ===== hdl/btd_back.sv =====
// Sequencer: holds slot state, executes commands and emits events.
module btd_back import btd_pkg::*; #(
  parameter int NUM_SLOTS  = 16,
  parameter int TIMER_BITS = 20
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [MAXRUN_W-1:0]          cfg_wdata,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  cmd_t                         cmd_op,
  input  logic [$clog2(NUM_SLOTS)-1:0] cmd_slot,
  input  logic [TIMER_BITS-1:0]        cmd_run,
  input  logic [TIMER_BITS-1:0]        cmd_can,
  btd_out_if.source                    evt
);
  localparam int SW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(NUM_SLOTS + 1);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_PICK  = 9'b000000010,
    ST_ACT   = 9'b000000100,
    ST_KILL2 = 9'b000001000,
    ST_TICK  = 9'b000010000,
    ST_DISP  = 9'b000100000,
    ST_START = 9'b001000000,
    ST_EMPTY = 9'b010000000,
    ST_FLUSH = 9'b100000000
  } state_t;

  typedef enum logic [1:0] {
    OP_CANCEL   = 2'd0,
    OP_KILL     = 2'd1,
    OP_COMPLETE = 2'd2
  } op_t;

  typedef struct packed {
    ev_t        ev;
    logic [3:0] slot;
    logic [3:0] flags;
  } evt_t;

  // Slot state
  logic [NUM_SLOTS-1:0]  queued;
  logic [NUM_SLOTS-1:0]  running;
  logic [NUM_SLOTS-1:0]  armed;
  logic [NUM_SLOTS-1:0]  fired;
  logic [NUM_SLOTS-1:0]  mask;
  logic [3:0]            flags   [NUM_SLOTS];
  logic [TIMER_BITS-1:0] timer   [NUM_SLOTS];
  logic [TIMER_BITS-1:0] run_lim [NUM_SLOTS];
  logic [TIMER_BITS-1:0] can_lim [NUM_SLOTS];
  logic [15:0]           order   [NUM_SLOTS];
  logic [15:0]           order_ctr;
  logic [CW-1:0]         run_cnt;
  logic                  halted;
  logic                  idle_rep;
  logic [MAXRUN_W-1:0]   max_run;

  // Sequencer state
  state_t        state;
  state_t        ret;
  op_t           op;
  logic [SW-1:0] cs;
  logic [SW-1:0] k;
  logic [SW-1:0] best;
  logic [15:0]   best_age;
  logic          found;
  logic          for_disp;
  logic          phase2;
  op_t           phase2_op;
  logic          phase2_run;

  // Event holding and output registers
  logic hv;
  evt_t held;
  logic ov;
  evt_t oreg;
  logic olast;

  // Combinational helpers
  logic          cur_q;
  logic          cur_r;
  logic [3:0]    cur_f;
  logic [SW+3:0] cs_ext;
  logic [15:0]   age_k;
  logic          take;
  logic          scan_end;
  logic          fin_found;
  logic [SW-1:0] fin_best;
  logic [SW-1:0] lo_fired;
  logic          room;
  logic          out_free;
  logic          can_emit;
  logic          e_req;
  evt_t          e_new;
  logic          stall;
  logic          e_go;
  logic          fl_stall;

  assign cur_q  = queued[cs];
  assign cur_r  = running[cs];
  assign cur_f  = flags[cs];
  assign cs_ext = {4'b0, cs};

  // Age compare for the oldest-first scan
  assign age_k     = order_ctr - order[k];
  assign take      = mask[k] && (!found || (age_k > best_age));
  assign scan_end  = (k == SW'(NUM_SLOTS - 1));
  assign fin_found = found || take;
  assign fin_best  = take ? k : best;

  assign room = (max_run == '0) || (8'(run_cnt) < 8'(max_run));

  // Lowest expired slot
  always_comb begin
    lo_fired = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (fired[i]) begin
        lo_fired = SW'(i);
      end
    end
  end

  assign out_free = !ov || evt.ready;
  assign can_emit = !hv || out_free;

  // Event produced in the current state
  always_comb begin
    e_req       = 1'b0;
    e_new.ev    = EV_DONE;
    e_new.slot  = cs_ext[3:0];
    e_new.flags = cur_f;
    case (state)
      ST_ACT: begin
        if (cur_q) begin
          e_req = 1'b1;
          if (cur_r && op == OP_CANCEL) begin
            e_new.ev    = EV_CANCEL;
            e_new.flags = cur_f | 4'(1 << F_CANCELLED);
          end else if (cur_r && op == OP_KILL) begin
            e_new.ev    = EV_KILL;
            e_new.flags = cur_f | 4'(1 << F_KILLED);
          end
        end
      end
      ST_KILL2: begin
        e_req = 1'b1;
      end
      ST_START: begin
        e_req    = 1'b1;
        e_new.ev = EV_RUN;
      end
      ST_EMPTY: begin
        if (!idle_rep && !(|queued)) begin
          e_req       = 1'b1;
          e_new.ev    = EV_EMPTY;
          e_new.slot  = '0;
          e_new.flags = '0;
        end
      end
      default: begin
        e_req = 1'b0;
      end
    endcase
  end

  assign stall    = e_req && !can_emit;
  assign e_go     = e_req && can_emit;
  assign fl_stall = hv && !out_free;

  assign cmd_ready = (state == ST_IDLE);

  // Drive the result channel
  assign evt.valid          = ov;
  assign evt.event_res      = oreg.ev;
  assign evt.task_res       = oreg.slot;
  assign evt.was_cancelled  = oreg.flags[F_CANCELLED];
  assign evt.was_killed     = oreg.flags[F_KILLED];
  assign evt.run_expired    = oreg.flags[F_RUN_EXP];
  assign evt.cancel_expired = oreg.flags[F_CANCEL_EXP];
  assign evt.last           = olast;

  // Hold, forward and flush events
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      hv <= 1'b0;
    end else begin
      if (e_go && hv) begin
        ov    <= 1'b1;
        oreg  <= held;
        olast <= 1'b0;
      end else if (state == ST_FLUSH && hv && out_free) begin
        ov    <= 1'b1;
        oreg  <= held;
        olast <= 1'b1;
      end else if (ov && evt.ready) begin
        ov <= 1'b0;
      end
      if (e_go) begin
        held <= e_new;
        hv   <= 1'b1;
      end else if (state == ST_FLUSH && hv && out_free) begin
        hv <= 1'b0;
      end
    end
  end

  // Slot payload that needs no reset
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd_valid && cmd_op == CMD_ADD && !halted && !queued[cmd_slot]) begin
      flags[cmd_slot]   <= '0;
      run_lim[cmd_slot] <= cmd_run;
      can_lim[cmd_slot] <= cmd_can;
      order[cmd_slot]   <= order_ctr;
    end
    if (state == ST_IDLE && cmd_valid && cmd_op == CMD_TICK) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (armed[i]) begin
          if (timer[i] == '0 || timer[i] == TIMER_BITS'(1)) begin
            timer[i] <= '0;
          end else begin
            timer[i] <= timer[i] - TIMER_BITS'(1);
          end
        end
      end
    end
    if (state == ST_TICK && |fired && queued[lo_fired] && running[lo_fired]) begin
      if (flags[lo_fired][F_CANCELLED]) begin
        flags[lo_fired][F_CANCEL_EXP] <= 1'b1;
      end else begin
        flags[lo_fired][F_RUN_EXP] <= 1'b1;
      end
    end
    if (e_go && state == ST_ACT && cur_r && op == OP_CANCEL) begin
      flags[cs] <= e_new.flags;
      timer[cs] <= can_lim[cs];
    end
    if (e_go && state == ST_ACT && cur_r && op == OP_KILL) begin
      flags[cs] <= e_new.flags;
    end
    if (e_go && state == ST_START) begin
      timer[cs] <= run_lim[cs];
    end
  end

  // Sequence commands
  always_ff @(posedge clk) begin
    if (rst) begin
      queued    <= '0;
      running   <= '0;
      armed     <= '0;
      fired     <= '0;
      mask      <= '0;
      order_ctr <= '0;
      run_cnt   <= '0;
      halted    <= 1'b0;
      idle_rep  <= 1'b1;
      max_run   <= '0;
      state     <= ST_IDLE;
      ret       <= ST_DISP;
      k         <= '0;
      found     <= 1'b0;
      for_disp  <= 1'b0;
      phase2    <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_run <= cfg_wdata;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            cs       <= cmd_slot;
            k        <= '0;
            found    <= 1'b0;
            for_disp <= 1'b0;
            phase2   <= (cmd_op == CMD_CANCEL_ALL) || (cmd_op == CMD_KILL_ALL);
            case (cmd_op)
              CMD_ADD: begin
                if (!halted && !queued[cmd_slot]) begin
                  queued[cmd_slot]  <= 1'b1;
                  running[cmd_slot] <= 1'b0;
                  order_ctr         <= order_ctr + 16'd1;
                  idle_rep          <= 1'b0;
                end
                ret   <= ST_DISP;
                state <= ST_DISP;
              end
              CMD_CANCEL: begin
                op    <= OP_CANCEL;
                ret   <= ST_DISP;
                state <= ST_ACT;
              end
              CMD_KILL: begin
                op    <= OP_KILL;
                ret   <= ST_DISP;
                state <= ST_ACT;
              end
              CMD_COMPLETE: begin
                op    <= OP_COMPLETE;
                ret   <= ST_DISP;
                state <= ST_ACT;
              end
              CMD_STOP: begin
                halted <= 1'b1;
                ret    <= ST_DISP;
                state  <= ST_DISP;
              end
              CMD_RESUME: begin
                halted <= 1'b0;
                ret    <= ST_DISP;
                state  <= ST_DISP;
              end
              CMD_CANCEL_PEND: begin
                mask  <= queued & ~running;
                op    <= OP_CANCEL;
                ret   <= ST_PICK;
                state <= ST_PICK;
              end
              CMD_CANCEL_RUN: begin
                mask  <= queued & running;
                op    <= OP_CANCEL;
                ret   <= ST_PICK;
                state <= ST_PICK;
              end
              CMD_CANCEL_ALL: begin
                mask       <= queued & ~running;
                op         <= OP_CANCEL;
                phase2_op  <= OP_CANCEL;
                phase2_run <= 1'b1;
                ret        <= ST_PICK;
                state      <= ST_PICK;
              end
              CMD_KILL_ALL: begin
                mask       <= queued & running;
                op         <= OP_KILL;
                phase2_op  <= OP_CANCEL;
                phase2_run <= 1'b0;
                ret        <= ST_PICK;
                state      <= ST_PICK;
              end
              CMD_TICK: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                  fired[i] <= armed[i] && (timer[i] == '0 || timer[i] == TIMER_BITS'(1));
                  if (armed[i] && (timer[i] == '0 || timer[i] == TIMER_BITS'(1))) begin
                    armed[i] <= 1'b0;
                  end
                end
                ret   <= ST_TICK;
                state <= ST_TICK;
              end
              default: begin
                ret   <= ST_DISP;
                state <= ST_DISP;
              end
            endcase
          end
        end

        // Visit one slot a cycle, keeping the oldest in the mask
        ST_PICK: begin
          if (scan_end) begin
            k     <= '0;
            found <= 1'b0;
            if (fin_found) begin
              mask[fin_best] <= 1'b0;
              cs             <= fin_best;
              state          <= for_disp ? ST_START : ST_ACT;
            end else if (phase2) begin
              mask   <= phase2_run ? (queued & running) : (queued & ~running);
              op     <= phase2_op;
              phase2 <= 1'b0;
            end else begin
              // A dispatch scan that finds nothing goes on to the empty check
              state <= for_disp ? ST_EMPTY : ST_DISP;
            end
          end else begin
            k <= k + SW'(1);
            if (take) begin
              best     <= k;
              best_age <= age_k;
              found    <= 1'b1;
            end
          end
        end

        // Cancel, kill or complete the current slot
        ST_ACT: begin
          if (!cur_q) begin
            state <= ret;
          end else if (!stall) begin
            if (cur_r && op == OP_CANCEL) begin
              armed[cs] <= |can_lim[cs];
              state     <= ret;
            end else if (cur_r && op == OP_KILL) begin
              state <= ST_KILL2;
            end else begin
              queued[cs]  <= 1'b0;
              running[cs] <= 1'b0;
              armed[cs]   <= 1'b0;
              if (cur_r && run_cnt != '0) begin
                run_cnt <= run_cnt - CW'(1);
              end
              state <= ret;
            end
          end
        end

        // Complete a slot after its kill request
        ST_KILL2: begin
          if (!stall) begin
            queued[cs]  <= 1'b0;
            running[cs] <= 1'b0;
            armed[cs]   <= 1'b0;
            if (cur_r && run_cnt != '0) begin
              run_cnt <= run_cnt - CW'(1);
            end
            state <= ret;
          end
        end

        // Handle expired timers in ascending slot order
        ST_TICK: begin
          if (|fired) begin
            fired[lo_fired] <= 1'b0;
            if (queued[lo_fired] && running[lo_fired]) begin
              cs    <= lo_fired;
              op    <= flags[lo_fired][F_CANCELLED] ? OP_KILL : OP_CANCEL;
              state <= ST_ACT;
            end
          end else begin
            state <= ST_DISP;
          end
        end

        // Unless halted, start pending tasks while there is room
        ST_DISP: begin
          if (halted) begin
            state <= ST_FLUSH;
          end else if (room) begin
            mask     <= queued & ~running;
            for_disp <= 1'b1;
            k        <= '0;
            found    <= 1'b0;
            phase2   <= 1'b0;
            state    <= ST_PICK;
          end else begin
            state <= ST_EMPTY;
          end
        end

        ST_START: begin
          if (!stall) begin
            running[cs] <= 1'b1;
            run_cnt     <= run_cnt + CW'(1);
            armed[cs]   <= |run_lim[cs];
            state       <= ST_DISP;
          end
        end

        // Report the queue becoming empty
        ST_EMPTY: begin
          if (!stall) begin
            if (e_req) begin
              idle_rep <= 1'b1;
            end
            state <= ST_FLUSH;
          end
        end

        // Release the held event as the last of this transaction
        ST_FLUSH: begin
          if (!fl_stall) begin
            state <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end
endmodule

// ===== hdl/bounded_task_dispatcher.sv =====
// Bounded task dispatcher: top level.
// Keeps NUM_SLOTS task slots in pending and running sets, ordered by age of
// add, and reports every run, cancel request, kill request and completion
// as an event, plus an event when the queue drains. Commands enter a
// two-entry buffer and the sequencer carries them out one at a time. A
// command is taken, does its own work, then dispatches pending tasks (or
// stops at once when halted, or skips to the empty check at the running
// cap) and releases its last held event. The age scan examines one slot
// per cycle for each oldest-first pick. Each state that emits an event
// waits while an event is held and the output register is full and not
// taken. The last event of a command is marked once the command has
// finished. The running cap on cfg_wdata may be written only while no
// command is in progress.
module bounded_task_dispatcher import btd_pkg::*; #(
  parameter int NUM_SLOTS  = 16,
  parameter int TIMER_BITS = 20
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [MAXRUN_W-1:0] cfg_wdata,
  btd_in_if.sink              cmd,
  btd_out_if.source           evt
);
  localparam int SW = $clog2(NUM_SLOTS);
  localparam int QW = KIND_W + SW + 2 * TIMER_BITS;

  logic                  push_valid;
  logic                  push_ready;
  cmd_t                  push_cmd;
  logic [SW-1:0]         push_slot;
  logic [TIMER_BITS-1:0] push_run;
  logic [TIMER_BITS-1:0] push_can;
  logic [QW-1:0]         push_data;
  logic                  pop_valid;
  logic                  pop_ready;
  logic [QW-1:0]         pop_data;
  logic [KIND_W-1:0]     pop_cmd_bits;
  logic [SW-1:0]         pop_slot;
  logic [TIMER_BITS-1:0] pop_run;
  logic [TIMER_BITS-1:0] pop_can;

  // Classify incoming commands
  btd_front #(
    .NUM_SLOTS  (NUM_SLOTS),
    .TIMER_BITS (TIMER_BITS)
  ) u_front (
    .cmd        (cmd),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .push_slot  (push_slot),
    .push_run   (push_run),
    .push_can   (push_can)
  );

  assign push_data = {push_cmd, push_slot, push_run, push_can};

  // Buffer classified commands
  btd_cmd_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign {pop_cmd_bits, pop_slot, pop_run, pop_can} = pop_data;

  // Execute commands and emit events
  btd_back #(
    .NUM_SLOTS  (NUM_SLOTS),
    .TIMER_BITS (TIMER_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd_op    (cmd_t'(pop_cmd_bits)),
    .cmd_slot  (pop_slot),
    .cmd_run   (pop_run),
    .cmd_can   (pop_can),
    .evt       (evt)
  );
endmodule

// ===== test/btd_checker.sv =====
// Event checker for the bounded task dispatcher: predicts events per command, compares them.
module btd_checker import btd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [MAXRUN_W-1:0] cfg_wdata,
  btd_in_if                   cmd,
  btd_out_if                  evt,
  output int                  fail_count,
  output int                  waiting_events,
  output int                  events_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NS = 16;

  typedef struct {
    ev_t        ev;
    logic [3:0] slot;
    logic [3:0] flags;
    logic       last;
  } sched_event_t;

  // Shadow of the dispatcher state
  logic                queued   [NS];
  logic                running  [NS];
  logic [3:0]          flags    [NS];
  logic [LIMIT_W-1:0]  timer    [NS];
  logic                armed    [NS];
  logic [LIMIT_W-1:0]  run_lim  [NS];
  logic [LIMIT_W-1:0]  can_lim  [NS];
  logic [15:0]         add_seq  [NS];
  logic [15:0]         seq_ctr;
  int                  run_cnt;
  logic                halted;
  logic                drained_told;
  logic [MAXRUN_W-1:0] max_run;

  sched_event_t due_events[$];
  sched_event_t step_events[$];

  assign waiting_events = due_events.size();

  function automatic logic [15:0] age(int s);
    return 16'(seq_ctr - add_seq[s]);
  endfunction

  function automatic void post(ev_t e, int s);
    sched_event_t x;
    x.ev = e;
    x.slot = 4'(s);
    x.flags = (e == EV_EMPTY) ? 4'd0 : flags[s];
    x.last = 1'b0;
    if (step_events.size() < 2 * NS + 1) step_events.push_back(x);
  endfunction

  // Collect queued slots of one running state, oldest first
  function automatic int by_age(logic want_run, ref int lst[NS]);
    int n, j;
    n = 0;
    for (int s = 0; s < NS; s++) begin
      if (!queued[s] || (running[s] != want_run)) continue;
      j = n;
      while (j > 0 && age(lst[j-1]) < age(s)) begin
        lst[j] = lst[j-1];
        j--;
      end
      lst[j] = s;
      n++;
    end
    return n;
  endfunction

  function automatic void arm(int s, logic [LIMIT_W-1:0] lim);
    armed[s] = (lim != 0);
    timer[s] = lim;
  endfunction

  function automatic void finish_task(int s);
    if (!queued[s]) return;
    if (running[s] && run_cnt > 0) run_cnt--;
    arm(s, '0);
    queued[s] = 1'b0;
    running[s] = 1'b0;
    post(EV_DONE, s);
  endfunction

  function automatic void kill_task(int s);
    if (!queued[s]) return;
    if (running[s]) begin
      flags[s][F_KILLED] = 1'b1;
      post(EV_KILL, s);
    end
    finish_task(s);
  endfunction

  function automatic void cancel_task(int s);
    if (!queued[s]) return;
    if (running[s]) begin
      flags[s][F_CANCELLED] = 1'b1;
      arm(s, can_lim[s]);
      post(EV_CANCEL, s);
    end else begin
      finish_task(s);
    end
  endfunction

  function automatic void cancel_set(logic want_run);
    int lst[NS];
    int n;
    n = by_age(want_run, lst);
    for (int i = 0; i < n; i++) cancel_task(lst[i]);
  endfunction

  function automatic void kill_set();
    int lst[NS];
    int n;
    n = by_age(1'b1, lst);
    for (int i = 0; i < n; i++) kill_task(lst[i]);
  endfunction

  function automatic void count_down();
    logic fired[NS];
    for (int s = 0; s < NS; s++) begin
      fired[s] = 1'b0;
      if (!armed[s]) continue;
      if (timer[s] > 0) timer[s]--;
      if (timer[s] == 0) begin
        armed[s] = 1'b0;
        fired[s] = 1'b1;
      end
    end
    for (int s = 0; s < NS; s++) begin
      if (!fired[s] || !queued[s] || !running[s]) continue;
      if (flags[s][F_CANCELLED]) begin
        flags[s][F_CANCEL_EXP] = 1'b1;
        kill_task(s);
      end else begin
        flags[s][F_RUN_EXP] = 1'b1;
        cancel_task(s);
      end
    end
  endfunction

  // Start oldest pending tasks, then report a drained queue
  function automatic void start_tasks();
    int lst[NS];
    int s;
    logic any;
    if (halted) return;
    while (max_run == 0 || run_cnt < max_run) begin
      if (by_age(1'b0, lst) == 0) break;
      s = lst[0];
      running[s] = 1'b1;
      run_cnt++;
      arm(s, run_lim[s]);
      post(EV_RUN, s);
    end
    any = 1'b0;
    for (int k = 0; k < NS; k++) if (queued[k]) any = 1'b1;
    if (!drained_told && !any) begin
      drained_told = 1'b1;
      post(EV_EMPTY, 0);
    end
  endfunction

  function automatic void predict(logic [3:0] k, int s, logic [19:0] rl, logic [19:0] cl);
    step_events.delete();
    case (k)
      CMD_ADD: if (!halted && !queued[s]) begin
        queued[s] = 1'b1;
        running[s] = 1'b0;
        flags[s] = '0;
        run_lim[s] = rl;
        can_lim[s] = cl;
        add_seq[s] = seq_ctr;
        seq_ctr = seq_ctr + 16'd1;
        drained_told = 1'b0;
      end
      CMD_CANCEL:      cancel_task(s);
      CMD_KILL:        kill_task(s);
      CMD_COMPLETE:    finish_task(s);
      CMD_STOP:        halted = 1'b1;
      CMD_RESUME:      halted = 1'b0;
      CMD_CANCEL_PEND: cancel_set(1'b0);
      CMD_CANCEL_RUN:  cancel_set(1'b1);
      CMD_CANCEL_ALL: begin
        cancel_set(1'b0);
        cancel_set(1'b1);
      end
      CMD_KILL_ALL: begin
        kill_set();
        cancel_set(1'b0);
      end
      CMD_TICK:        count_down();
      default: ;
    endcase
    start_tasks();
    if (step_events.size() > 0) step_events[$].last = 1'b1;
    foreach (step_events[i]) due_events.push_back(step_events[i]);
  endfunction

  // Track config, predict on each command transaction, check each event transaction
  always @(posedge clk) begin
    sched_event_t x;
    logic bad;
    if (rst) begin
      for (int s = 0; s < NS; s++) begin
        queued[s] = 1'b0; running[s] = 1'b0; flags[s] = '0;
        timer[s] = '0; armed[s] = 1'b0; run_lim[s] = '0; can_lim[s] = '0;
        add_seq[s] = '0;
      end
      seq_ctr = '0;
      run_cnt = 0;
      halted = 1'b0;
      drained_told = 1'b1;
      max_run = '0;
      due_events.delete();
      fail_count = 0;
      events_seen = 0;
    end else begin
      if (cfg_we) max_run = cfg_wdata;
      if (cmd.valid && cmd.ready)
        predict(cmd.kind, int'(cmd.slot), cmd.run_limit_ms, cmd.cancel_limit_ms);
      if (evt.valid && evt.ready) begin
        events_seen++;
        if (due_events.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: unexpected event %0d slot %0d", evt.event_res, evt.task_res);
        end else begin
          x = due_events.pop_front();
          bad = (evt.event_res != x.ev) || (evt.task_res != x.slot) ||
                (evt.was_cancelled != x.flags[F_CANCELLED]) ||
                (evt.was_killed != x.flags[F_KILLED]) ||
                (evt.run_expired != x.flags[F_RUN_EXP]) ||
                (evt.cancel_expired != x.flags[F_CANCEL_EXP]) ||
                (evt.last != x.last);
          if (bad) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"ERROR: exp ev %0d slot %0d flags %b last %b, ",
                        "got ev %0d slot %0d flags %b%b%b%b last %b"},
                       x.ev, x.slot, x.flags, x.last, evt.event_res, evt.task_res,
                       evt.cancel_expired, evt.run_expired, evt.was_killed,
                       evt.was_cancelled, evt.last);
          end
        end
      end
    end
  end
endmodule

// ===== test/tb.sv =====
// Testbench top of the bounded task dispatcher: clock, reset, stimulus and verdict.
module tb import btd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 1000;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [MAXRUN_W-1:0] cfg_wdata;
  int                  fail_count, waiting_events, events_seen;
  int                  cmds_sent;
  int                  quiet_cycles;
  logic                idle_on;
  logic                hold_req;

  btd_in_if  cmd_ch();
  btd_out_if evt_ch();

  bounded_task_dispatcher dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .cmd(cmd_ch), .evt(evt_ch)
  );

  btd_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .cmd(cmd_ch), .evt(evt_ch), .fail_count(fail_count),
    .waiting_events(waiting_events), .events_seen(events_seen)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Offer one command and hold it until the transaction completes
  task automatic send_cmd(input logic [3:0] k, input logic [3:0] s,
                          input logic [19:0] rl, input logic [19:0] cl);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.kind <= k;
    cmd_ch.slot <= s;
    cmd_ch.run_limit_ms <= rl;
    cmd_ch.cancel_limit_ms <= cl;
    @(negedge clk);
    while (!cmd_ch.ready) @(negedge clk);
    @(posedge clk);
    cmds_sent++;
  endtask

  // Mostly short timers so tasks expire; now and then a full-range limit
  function automatic logic [19:0] pick_limit();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 20'd0;
    if (r == 1) return 20'($urandom);
    return 20'($urandom_range(1, 6));
  endfunction

  task automatic random_cmd();
    int r;
    logic [3:0] s;
    r = $urandom_range(0, 99);
    s = 4'($urandom_range(0, 15));
    if (r < 35)      send_cmd(CMD_ADD, s, pick_limit(), pick_limit());
    else if (r < 60) send_cmd(CMD_TICK, s, 20'($urandom), 20'($urandom));
    else if (r < 68) send_cmd(CMD_CANCEL, s, '0, '0);
    else if (r < 73) send_cmd(CMD_KILL, s, '0, '0);
    else if (r < 79) send_cmd(CMD_COMPLETE, s, '0, '0);
    else if (r < 82) send_cmd(CMD_STOP, s, '0, '0);
    else if (r < 88) send_cmd(CMD_RESUME, s, '0, '0);
    else if (r < 90) send_cmd(CMD_CANCEL_PEND, s, '0, '0);
    else if (r < 92) send_cmd(CMD_CANCEL_RUN, s, '0, '0);
    else if (r < 94) send_cmd(CMD_CANCEL_ALL, s, '0, '0);
    else if (r < 96) send_cmd(CMD_KILL_ALL, s, '0, '0);
    else             send_cmd(4'($urandom_range(11, 15)), s, 20'($urandom), 20'($urandom));
  endtask

  // Stop offering, drain everything, let silent commands finish, then write the cap
  task automatic set_run_cap(input logic [MAXRUN_W-1:0] v);
    cmd_ch.valid <= 1'b0;
    while (waiting_events != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Event side: random stall bursts plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        evt_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        evt_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      evt_ch.ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any transaction
  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((cmd_ch.valid && cmd_ch.ready) || (evt_ch.valid && evt_ch.ready) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TIMEOUT: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    logic [MAXRUN_W-1:0] phase_max [4];
    int wait_cnt;
    phase_max = '{5'd1, 5'd16, 5'd3, 5'd0};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.kind = '0;
    cmd_ch.slot = '0;
    cmd_ch.run_limit_ms = '0;
    cmd_ch.cancel_limit_ms = '0;
    evt_ch.ready = 1'b0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    cmds_sent = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, timer expiry chains, halting, list commands, odd kinds
    send_cmd(CMD_ADD, 4'd0, 20'd1, 20'd1);
    send_cmd(CMD_ADD, 4'd15, 20'hFFFFF, 20'hFFFFF);
    send_cmd(CMD_ADD, 4'd15, 20'd3, 20'd3);
    send_cmd(CMD_TICK, 4'd0, '0, '0);
    send_cmd(CMD_TICK, 4'd0, '0, '0);
    send_cmd(CMD_CANCEL, 4'd15, '0, '0);
    send_cmd(CMD_CANCEL, 4'd15, '0, '0);
    send_cmd(CMD_KILL, 4'd15, '0, '0);
    send_cmd(CMD_KILL, 4'd7, '0, '0);
    send_cmd(CMD_STOP, 4'd0, '0, '0);
    send_cmd(CMD_ADD, 4'd3, 20'd2, 20'd0);
    send_cmd(CMD_RESUME, 4'd0, '0, '0);
    send_cmd(CMD_ADD, 4'd4, 20'd0, 20'd0);
    send_cmd(CMD_ADD, 4'd5, 20'd2, 20'd0);
    send_cmd(CMD_STOP, 4'd0, '0, '0);
    send_cmd(CMD_ADD, 4'd6, 20'd1, 20'd1);
    send_cmd(CMD_RESUME, 4'd0, '0, '0);
    send_cmd(CMD_CANCEL_RUN, 4'd0, '0, '0);
    send_cmd(CMD_TICK, 4'd0, '0, '0);
    send_cmd(CMD_CANCEL_PEND, 4'd0, '0, '0);
    send_cmd(CMD_COMPLETE, 4'd4, '0, '0);
    send_cmd(CMD_CANCEL_ALL, 4'd0, '0, '0);
    send_cmd(CMD_KILL_ALL, 4'd0, '0, '0);
    send_cmd(4'd15, 4'd15, 20'hFFFFF, 20'hFFFFF);
    send_cmd(CMD_NOP, 4'd0, '0, '0);

    // Random phases across running caps; long event hold-off in the second
    for (int p = 0; p < 4; p++) begin
      set_run_cap(phase_max[p]);
      if (p == 3) idle_on = 1'b0;
      for (int i = 0; i < 48; i++) begin
        if (p == 1 && i == 10) hold_req = 1'b1;
        random_cmd();
      end
      send_cmd(CMD_RESUME, 4'd0, '0, '0);
      send_cmd(CMD_KILL_ALL, 4'd0, '0, '0);
    end
    cmd_ch.valid <= 1'b0;

    wait_cnt = 0;
    while (waiting_events != 0 && wait_cnt < WATCHDOG_LIMIT) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (waiting_events != 0) begin
      $display("ERROR: %0d expected events never arrived", waiting_events);
    end
    $display("Sent %0d commands with the cap unlimited, then at 1, 16, 3 and unlimited again,",
             cmds_sent);
    $display("covering timer expiry, halting, list commands and output stalls; %0d events.",
             events_seen);
    if (fail_count == 0 && waiting_events == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
